/* src/sqd_pkg.sv */
// ---------------------------------------------------------------------------
// sqd_pkg - shared definitions for the deque chain
// Sizes, operation codes and the per-cell control word.
// ---------------------------------------------------------------------------
package sqd_pkg;

  // Number of entries held in the row of cells (2..64)
  localparam int DEPTH = 16;
  // Width of a position inside the row
  localparam int IDX_W = $clog2(DEPTH);
  // Width of the fill count, which can reach DEPTH itself
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam int DATA_W = 32;

  // Operation codes carried on in_tuser
  localparam logic [1:0] FUNC_REMOVE = 2'd0;
  localparam logic [1:0] FUNC_INSERT = 2'd1;
  localparam logic [1:0] FUNC_APPEND = 2'd2;

  // What a cell does with its entry
  typedef enum logic [1:0] {
    CELL_HOLD      = 2'd0,  // keep the entry
    CELL_SHIFT_IN  = 2'd1,  // take the left neighbor's entry (toward the back)
    CELL_SHIFT_OUT = 2'd2,  // take the right neighbor's entry, or wrap if target
    CELL_LOAD      = 2'd3   // take the new value if target
  } cell_op_t;

  typedef struct packed {
    cell_op_t op;
    logic     target;
  } cell_ctrl_t;

endpackage

/* src/sqd_cell.sv */
// ---------------------------------------------------------------------------
// sqd_cell - one storage cell of the deque chain
// Holds a single entry and moves it to or from its neighbors.
// ---------------------------------------------------------------------------
module sqd_cell
  import sqd_pkg::*;
(
  input  logic              clk,
  input  cell_ctrl_t        ctrl,
  input  logic [DATA_W-1:0] left_in,   // entry of the cell toward the front
  input  logic [DATA_W-1:0] right_in,  // entry of the cell toward the back
  input  logic [DATA_W-1:0] wrap_in,   // front entry, for rotation
  input  logic [DATA_W-1:0] load_in,   // new value from the input channel
  output logic [DATA_W-1:0] data_out
);

  logic [DATA_W-1:0] data_r;
  logic [DATA_W-1:0] data_nxt;

  // Select the next entry for this cell
  always_comb begin
    data_nxt = data_r;
    case (ctrl.op)
      CELL_HOLD:      data_nxt = data_r;
      CELL_SHIFT_IN:  data_nxt = left_in;
      CELL_SHIFT_OUT: data_nxt = ctrl.target ? wrap_in : right_in;
      CELL_LOAD:      data_nxt = ctrl.target ? load_in : data_r;
      default:        data_nxt = data_r;
    endcase
  end

  always_ff @(posedge clk) begin
    data_r <= data_nxt;
  end

  assign data_out = data_r;

endmodule

/* src/stack_queue_deque_top.sv */
// ---------------------------------------------------------------------------
// stack_queue_deque_top - bounded deque of signed 32-bit values
// Remove front, insert front or append back, then list the whole contents.
// ---------------------------------------------------------------------------
// The deque lives in a row of DEPTH cells with the front entry in cell 0
// between listings. An operation is applied to the row in the cycle its
// transaction is accepted. The contents are then listed front to back, one
// result per cycle while the output is not stalled, by rotating the row one
// cell toward the front per result, so the row is back in order after the
// last one; an empty deque gives a single result with the empty flag set.
// The input is not taken while a listing is in progress; the last result
// may still wait in the output register while the next item is taken. An
// insert or append into a full deque is dropped and every result of that
// item carries the overflow flag. Operation code three acts as append.
// ---------------------------------------------------------------------------
module stack_queue_deque_top
  import sqd_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_tvalid,
  output logic              in_tready,
  input  logic [DATA_W-1:0] in_tdata,   // [31:0] item_value
  input  logic [1:0]        in_tuser,   // [1:0] func
  output logic              out_tvalid,
  input  logic              out_tready,
  output logic [DATA_W-1:0] out_tdata,  // [31:0] entry_value
  output logic [1:0]        out_tuser,  // [0] is_empty, [1] overflow
  output logic              out_tlast   // is_last
);

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_DUMP = 2'b10
  } state_t;

  state_t            state_r, state_nxt;
  logic [CNT_W-1:0]  count_r, count_nxt;
  logic [IDX_W-1:0]  pos_r, pos_nxt;
  logic              ovf_r, ovf_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic [DATA_W-1:0] out_data_r;
  logic              out_empty_r, out_last_r, out_ovf_r;

  logic              accept;
  logic              full;
  logic              out_free;
  logic              dump_step;
  logic              last_step;
  logic [CNT_W-1:0]  tail_cnt;

  cell_ctrl_t        cell_ctrl [DEPTH];
  logic [DATA_W-1:0] cell_data [DEPTH];

  assign in_tready = (state_r == ST_IDLE);
  assign accept    = in_tvalid & in_tready;
  assign full      = (count_r == CNT_W'(DEPTH));
  assign out_free  = ~out_valid_r | out_tready;
  assign dump_step = (state_r == ST_DUMP) & out_free;
  assign tail_cnt  = count_r - CNT_W'(1);
  assign last_step = (count_r == '0) || (pos_r == tail_cnt[IDX_W-1:0]);

  // Drive the cell row: apply the operation on accept, rotate while listing
  always_comb begin
    for (int i = 0; i < DEPTH; i++) begin
      cell_ctrl[i].op     = CELL_HOLD;
      cell_ctrl[i].target = 1'b0;
      if (accept) begin
        case (in_tuser)
          FUNC_REMOVE: begin
            if (count_r != '0) cell_ctrl[i].op = CELL_SHIFT_OUT;
          end
          FUNC_INSERT: begin
            if (!full) cell_ctrl[i].op = CELL_SHIFT_IN;
          end
          default: begin
            if (!full) begin
              cell_ctrl[i].op     = CELL_LOAD;
              cell_ctrl[i].target = (CNT_W'(i) == count_r);
            end
          end
        endcase
      end else if (dump_step && count_r != '0) begin
        cell_ctrl[i].op     = CELL_SHIFT_OUT;
        cell_ctrl[i].target = (CNT_W'(i) == tail_cnt);
      end
    end
  end

  // Build the chain of cells
  for (genvar g = 0; g < DEPTH; g++) begin : g_cell
    sqd_cell u_cell (
      .clk      (clk),
      .ctrl     (cell_ctrl[g]),
      .left_in  ((g == 0) ? in_tdata : cell_data[(g == 0) ? 0 : g - 1]),
      .right_in ((g == DEPTH - 1) ? cell_data[0]
                                  : cell_data[(g == DEPTH - 1) ? 0 : g + 1]),
      .wrap_in  (cell_data[0]),
      .load_in  (in_tdata),
      .data_out (cell_data[g])
    );
  end

  // Sequence the operation and the listing
  always_comb begin
    state_nxt     = state_r;
    count_nxt     = count_r;
    pos_nxt       = pos_r;
    ovf_nxt       = ovf_r;
    out_valid_nxt = out_valid_r & ~out_tready;
    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          ovf_nxt   = 1'b0;
          pos_nxt   = '0;
          state_nxt = ST_DUMP;
          if (in_tuser == FUNC_REMOVE) begin
            if (count_r != '0) count_nxt = count_r - CNT_W'(1);
          end else if (full) begin
            ovf_nxt = 1'b1;
          end else begin
            count_nxt = count_r + CNT_W'(1);
          end
        end
      end
      ST_DUMP: begin
        if (dump_step) begin
          out_valid_nxt = 1'b1;
          if (last_step) begin
            state_nxt = ST_IDLE;
          end else begin
            pos_nxt = pos_r + IDX_W'(1);
          end
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      count_r     <= '0;
      pos_r       <= '0;
      ovf_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      pos_r       <= pos_nxt;
      ovf_r       <= ovf_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Load the output register with the front entry
  always_ff @(posedge clk) begin
    if (dump_step) begin
      out_data_r  <= (count_r == '0) ? '0 : cell_data[0];
      out_empty_r <= (count_r == '0);
      out_last_r  <= last_step;
      out_ovf_r   <= ovf_r;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = {out_ovf_r, out_empty_r};
  assign out_tlast  = out_last_r;

  // The fill count never passes the row length
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(DEPTH))
    else $error("fill count above depth");

  // The count moves only on an accepted transaction
  a_count_stable: assert property (@(posedge clk) disable iff (!rst_n)
    !accept |=> $stable(count_r))
    else $error("fill count changed without a transaction");

  // A dropped insert leaves the count unchanged and flags overflow
  a_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && full && in_tuser != FUNC_REMOVE) |=> ($stable(count_r) && ovf_r))
    else $error("insert into full deque not dropped");

  // An empty result is always the last of its item
  a_empty_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_empty_r) |-> out_last_r)
    else $error("empty result without last marker");

endmodule

/* sim/sqd_checker.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// sqd_checker - listing predictor and scoreboard for the deque
// Watches both stream channels, keeps its own copy of the ring, predicts the
// listing that each accepted operation produces and compares every accepted
// result against the oldest prediction still waiting.
// ---------------------------------------------------------------------------
module sqd_checker
  import sqd_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_tvalid,
  input  logic              in_tready,
  input  logic [DATA_W-1:0] in_tdata,   // [31:0] item_value
  input  logic [1:0]        in_tuser,   // [1:0] func
  input  logic              out_tvalid,
  input  logic              out_tready,
  input  logic [DATA_W-1:0] out_tdata,  // [31:0] entry_value
  input  logic [1:0]        out_tuser,  // [0] is_empty, [1] overflow
  input  logic              out_tlast,
  output int                mismatch_count,
  output int                pending_count,
  output int                items_seen,
  output int                results_seen,
  output int                overflow_seen,
  output int                empty_seen
);

  localparam int REPORT_MAX    = 10;
  localparam int USER_EMPTY_BIT = 0;
  localparam int USER_OVF_BIT   = 1;

  typedef struct packed {
    logic [DATA_W-1:0] entry_value;
    logic              is_empty;
    logic              is_last;
    logic              overflow;
  } listing_t;

  // Shadow ring: front position and fill level
  logic [DATA_W-1:0] ring_shadow [DEPTH];
  int                ring_front;
  int                ring_fill;
  listing_t          listing_q [$];

  // Apply one operation to the shadow ring and queue the listing it causes
  task automatic predict_listing(input logic [1:0] func, input logic [DATA_W-1:0] value);
    logic     dropped;
    listing_t want;
    dropped = 1'b0;
    if (func == FUNC_REMOVE) begin
      if (ring_fill != 0) begin
        ring_front = (ring_front + 1) % DEPTH;
        ring_fill--;
      end
    end else if (ring_fill >= DEPTH) begin
      dropped = 1'b1;
    end else if (func == FUNC_INSERT) begin
      ring_front = (ring_front + DEPTH - 1) % DEPTH;
      ring_shadow[ring_front] = value;
      ring_fill++;
    end else begin
      // append, and code three behaves the same
      ring_shadow[(ring_front + ring_fill) % DEPTH] = value;
      ring_fill++;
    end
    if (dropped) overflow_seen++;

    if (ring_fill == 0) begin
      want.entry_value = '0;
      want.is_empty    = 1'b1;
      want.is_last     = 1'b1;
      want.overflow    = dropped;
      listing_q.push_back(want);
      empty_seen++;
    end else begin
      for (int k = 0; k < ring_fill; k++) begin
        want.entry_value = ring_shadow[(ring_front + k) % DEPTH];
        want.is_empty    = 1'b0;
        want.is_last     = (k + 1 == ring_fill);
        want.overflow    = dropped;
        listing_q.push_back(want);
      end
    end
  endtask

  // Compare results first: a result in the same cycle as a new operation
  // always belongs to an earlier operation
  always @(posedge clk) begin
    listing_t got;
    listing_t want;
    if (!rst_n) begin
      ring_front     = 0;
      ring_fill      = 0;
      listing_q.delete();
      mismatch_count = 0;
      items_seen     = 0;
      results_seen   = 0;
      overflow_seen  = 0;
      empty_seen     = 0;
    end else begin
      if (out_tvalid && out_tready) begin
        got.entry_value = out_tdata;
        got.is_empty    = out_tuser[USER_EMPTY_BIT];
        got.is_last     = out_tlast;
        got.overflow    = out_tuser[USER_OVF_BIT];
        results_seen++;
        if (listing_q.size() == 0) begin
          mismatch_count++;
          if (mismatch_count <= REPORT_MAX)
            $display("unexpected result: value %h empty %b last %b ovf %b",
                     got.entry_value, got.is_empty, got.is_last, got.overflow);
        end else begin
          want = listing_q.pop_front();
          if (got.entry_value !== want.entry_value || got.is_empty !== want.is_empty ||
              got.is_last !== want.is_last || got.overflow !== want.overflow) begin
            mismatch_count++;
            if (mismatch_count <= REPORT_MAX)
              $display("result %0d mismatch: expected value %h empty %b last %b ovf %b,",
                       results_seen, want.entry_value, want.is_empty, want.is_last,
                       want.overflow, " got value %h empty %b last %b ovf %b",
                       got.entry_value, got.is_empty, got.is_last, got.overflow);
          end
        end
      end
      if (in_tvalid && in_tready) begin
        items_seen++;
        predict_listing(in_tuser, in_tdata);
      end
    end
    pending_count = listing_q.size();
  end

endmodule

/* sim/tb_stack_queue_deque_top.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb_stack_queue_deque_top - stream testbench for the bounded deque
// Drives remove, insert and append operations, directed at the corner cases
// and then in random grow and shrink bursts, under three idle patterns and
// one long output stall; the checker scores every listed entry.
// ---------------------------------------------------------------------------
module tb_stack_queue_deque_top;
  import sqd_pkg::*;

  localparam int CLK_HALF     = 6;
  localparam int RESET_CYCLES = 4;
  localparam int PHASE_ITEMS  = 117;
  localparam int HOLD_CYCLES  = 300;
  localparam int SETTLE_CYCLES = 2 * (DEPTH + 1) + 8;
  localparam int CYCLE_LIMIT  = 400000;

  // Unassigned operation code, decoded as append
  localparam logic [1:0] FUNC_ALT_APPEND = 2'd3;

  localparam logic [DATA_W-1:0] VAL_MOST_NEG = 32'h8000_0000;
  localparam logic [DATA_W-1:0] VAL_MOST_POS = 32'h7FFF_FFFF;
  localparam logic [DATA_W-1:0] VAL_ALL_ONES = 32'hFFFF_FFFF;
  localparam logic [DATA_W-1:0] VAL_ZERO     = 32'h0000_0000;

  // Burst flavors for the random part
  localparam int MODE_GROW   = 0;
  localparam int MODE_SHRINK = 1;
  localparam int MODE_MIXED  = 2;
  localparam int MODE_NOISE  = 3;

  logic              clk        = 1'b0;
  logic              rst_n      = 1'b0;
  logic              in_tvalid  = 1'b0;
  logic              in_tready;
  logic [DATA_W-1:0] in_tdata   = '0;    // [31:0] item_value
  logic [1:0]        in_tuser   = '0;    // [1:0] func
  logic              out_tvalid;
  logic              out_tready = 1'b0;
  logic [DATA_W-1:0] out_tdata;          // [31:0] entry_value
  logic [1:0]        out_tuser;          // [0] is_empty, [1] overflow
  logic              out_tlast;

  int   send_idle_pct = 27;
  int   recv_idle_pct = 71;
  logic hold_armed    = 1'b0;
  logic hold_done     = 1'b0;
  int   hold_left     = 0;
  int   cycle_count   = 0;

  int mismatch_count, pending_count, items_seen, results_seen, overflow_seen, empty_seen;

  always #(CLK_HALF) clk = ~clk;

  stack_queue_deque_top DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

  sqd_checker u_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_tvalid      (in_tvalid),
    .in_tready      (in_tready),
    .in_tdata       (in_tdata),
    .in_tuser       (in_tuser),
    .out_tvalid     (out_tvalid),
    .out_tready     (out_tready),
    .out_tdata      (out_tdata),
    .out_tuser      (out_tuser),
    .out_tlast      (out_tlast),
    .mismatch_count (mismatch_count),
    .pending_count  (pending_count),
    .items_seen     (items_seen),
    .results_seen   (results_seen),
    .overflow_seen  (overflow_seen),
    .empty_seen     (empty_seen)
  );

  // Hard stop on a hung run
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results still due", cycle_count, pending_count);
      $display("status: fail");
      $finish;
    end
  end

  // Drive out_tready: random idling, plus one long hold-off once armed
  always @(negedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left  <= hold_left - 1;
      out_tready <= 1'b0;
    end else if (hold_armed && !hold_done) begin
      hold_left  <= HOLD_CYCLES;
      hold_done  <= 1'b1;
      out_tready <= 1'b0;
    end else begin
      out_tready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // Offer one transaction from a falling edge, hold it until accepted
  task automatic send_item(input logic [1:0] func, input logic [DATA_W-1:0] value);
    while ($urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= value;
    in_tuser  <= func;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    @(negedge clk);
  endtask

  function automatic logic [1:0] pick_add();
    int roll;
    roll = $urandom_range(99);
    if (roll < 45) return FUNC_INSERT;
    else if (roll < 90) return FUNC_APPEND;
    else return FUNC_ALT_APPEND;
  endfunction

  function automatic logic [1:0] pick_func(input int mode);
    int roll;
    roll = $urandom_range(99);
    case (mode)
      MODE_GROW:   return (roll < 75) ? pick_add() : FUNC_REMOVE;
      MODE_SHRINK: return (roll < 75) ? FUNC_REMOVE : pick_add();
      MODE_MIXED:  return (roll < 40) ? FUNC_REMOVE : pick_add();
      default: begin
        case ($urandom_range(3))
          0:       return FUNC_REMOVE;
          1:       return FUNC_INSERT;
          2:       return FUNC_APPEND;
          default: return FUNC_ALT_APPEND;
        endcase
      end
    endcase
  endfunction

  function automatic logic [DATA_W-1:0] pick_value();
    if ($urandom_range(7) != 0) return $urandom;
    case ($urandom_range(3))
      0:       return VAL_MOST_NEG;
      1:       return VAL_MOST_POS;
      2:       return VAL_ALL_ONES;
      default: return VAL_ZERO;
    endcase
  endfunction

  // Random bursts that push the deque toward full or empty in turn
  task automatic run_random(input int n_items);
    int mode;
    int burst_left;
    int roll;
    burst_left = 0;
    mode = MODE_MIXED;
    for (int i = 0; i < n_items; i++) begin
      if (burst_left == 0) begin
        roll = $urandom_range(99);
        if (roll < 35) mode = MODE_GROW;
        else if (roll < 65) mode = MODE_SHRINK;
        else if (roll < 90) mode = MODE_MIXED;
        else mode = MODE_NOISE;
        burst_left = $urandom_range(28, 8);
      end
      send_item(pick_func(mode), pick_value());
      burst_left--;
    end
  endtask

  initial begin
    repeat (RESET_CYCLES) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed: remove on empty, extreme values, every code
    send_item(FUNC_REMOVE, VAL_ALL_ONES);
    send_item(FUNC_INSERT, VAL_MOST_POS);
    send_item(FUNC_APPEND, VAL_MOST_NEG);
    send_item(FUNC_ALT_APPEND, VAL_ALL_ONES);
    send_item(FUNC_INSERT, VAL_ZERO);
    // Fill to capacity, then try both kinds of add on a full deque
    for (int i = 0; i < DEPTH - 4; i++) send_item(FUNC_APPEND, $urandom);
    send_item(FUNC_INSERT, VAL_MOST_NEG);
    send_item(FUNC_ALT_APPEND, VAL_MOST_POS);
    // Free one slot, refill with code three, then drain a little
    send_item(FUNC_REMOVE, VAL_ZERO);
    send_item(FUNC_ALT_APPEND, VAL_MOST_NEG);
    send_item(FUNC_REMOVE, VAL_MOST_POS);
    send_item(FUNC_REMOVE, VAL_ZERO);

    run_random(PHASE_ITEMS);

    // Swap the idle rates
    send_idle_pct = 71;
    recv_idle_pct <= 27;
    run_random(PHASE_ITEMS);

    // No idling; start with a long output stall so the input backs up
    send_idle_pct = 0;
    recv_idle_pct <= 0;
    hold_armed    <= 1'b1;
    run_random(PHASE_ITEMS);

    in_tvalid <= 1'b0;
    while (pending_count != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);

    $display("run covered %0d operations and %0d listed results in %0d cycles",
             items_seen, results_seen, cycle_count);
    $display("including %0d dropped adds on a full deque and %0d empty listings",
             overflow_seen, empty_seen);
    if (mismatch_count == 0) begin
      $display("status: pass");
    end else begin
      $display("%0d mismatches", mismatch_count);
      $display("status: fail");
    end
    $finish;
  end

endmodule
